FILE: hw/rtl/paged_mono_framebuffer_macros.svh
// assertion macros for the paged mono framebuffer checker
// depends on clk and rst being visible where a macro is used
`ifndef PAGED_MONO_FRAMEBUFFER_MACROS_SVH
`define PAGED_MONO_FRAMEBUFFER_MACROS_SVH

// same-cycle implication, off during reset
`define PMFB_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define PMFB_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// what reset must leave behind in the cycle after it
`define PMFB_ASSERT_RESET(name, cons, msg) \
  name: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/pmfb_pkg.sv
// shared types and codes of the paged mono framebuffer
// no dependencies
package pmfb_pkg;

  // request function codes
  localparam logic [1:0] FUNC_POINT = 2'd0;
  localparam logic [1:0] FUNC_FILL  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;
  localparam logic [1:0] FUNC_READ  = 2'd3;

  // pixel modes, the unused code acts as off
  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_ON     = 2'd1;
  localparam logic [1:0] MODE_INVERT = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_CLIP_X_LO = 2'd0;
  localparam logic [1:0] CFG_CLIP_X_HI = 2'd1;
  localparam logic [1:0] CFG_CLIP_Y_LO = 2'd2;
  localparam logic [1:0] CFG_CLIP_Y_HI = 2'd3;

  // work kinds handed from front to back
  localparam logic [1:0] KIND_DONE  = 2'd0;
  localparam logic [1:0] KIND_DRAW  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;
  localparam logic [1:0] KIND_READ  = 2'd3;

  localparam logic [7:0] BYTE_ONES  = 8'hff;
  localparam logic [7:0] BYTE_ZEROS = 8'h00;

  // classified request, rectangles are inclusive and already clipped
  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] mode;
    logic       oor;
    logic [7:0] col_first;
    logic [7:0] col_last;
    logic [7:0] row_first;
    logic [7:0] row_last;
  } cmd_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       oor;
  } res_t;

endpackage

FILE: hw/rtl/pmfb_fifo.sv
// small first-in first-out queue used between the framebuffer stages
// depends on nothing
module pmfb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTRW-1:0]  wr_ptr;
  logic [PTRW-1:0]  rd_ptr;
  logic [CNTW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNTW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTRW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTRW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/pmfb_front.sv
// request classifier: holds the clip window and turns each request into work
// depends on pmfb_pkg
module pmfb_front import pmfb_pkg::*; #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [1:0] func,
  input  logic [7:0] x_a,
  input  logic [7:0] y_a,
  input  logic [7:0] x_b,
  input  logic [7:0] y_b,
  input  logic [1:0] pixel_mode,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       cmd_full,
  output logic       cmd_push,
  output cmd_t       cmd
);

  localparam logic [8:0] COLS9  = 9'(COLUMNS);
  localparam logic [8:0] ROWS9  = 9'(PAGES * 8);
  localparam logic [8:0] PAGES9 = 9'(PAGES);

  logic [7:0] clip_x_lo;
  logic [7:0] clip_x_hi;
  logic [6:0] clip_y_lo;
  logic [6:0] clip_y_hi;

  logic       pt_ok;
  logic       rd_ok;
  logic [7:0] col_lo;
  logic [7:0] row_lo;
  logic [8:0] col_end;
  logic [8:0] row_end;
  logic       fill_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_x_lo <= 8'd0;
      clip_x_hi <= 8'd128;
      clip_y_lo <= 7'd0;
      clip_y_hi <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CLIP_X_LO: clip_x_lo <= cfg_data;
        CFG_CLIP_X_HI: clip_x_hi <= cfg_data;
        CFG_CLIP_Y_LO: clip_y_lo <= cfg_data[6:0];
        CFG_CLIP_Y_HI: clip_y_hi <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign cmd_push = push && !cmd_full;

  // single pixel inside store and clip window
  assign pt_ok = ({1'b0, x_a} < COLS9) && ({1'b0, y_a} < ROWS9)
              && (x_a >= clip_x_lo) && (x_a < clip_x_hi)
              && (y_a >= {1'b0, clip_y_lo}) && (y_a < {1'b0, clip_y_hi});

  assign rd_ok = ({1'b0, x_a} < COLS9) && ({1'b0, y_a} < PAGES9);

  // rectangle clipped against window and store
  always_comb begin
    col_lo  = (x_a > clip_x_lo) ? x_a : clip_x_lo;
    row_lo  = (y_a > {1'b0, clip_y_lo}) ? y_a : {1'b0, clip_y_lo};
    col_end = (x_b < clip_x_hi) ? {1'b0, x_b} : {1'b0, clip_x_hi};
    if (COLS9 < col_end) begin
      col_end = COLS9;
    end
    row_end = (y_b < {1'b0, clip_y_hi}) ? {1'b0, y_b} : {2'b00, clip_y_hi};
    if (ROWS9 < row_end) begin
      row_end = ROWS9;
    end
    fill_ok = ({1'b0, col_lo} < col_end) && ({1'b0, row_lo} < row_end);
  end

  always_comb begin
    cmd      = '0;
    cmd.mode = pixel_mode;
    case (func)
      FUNC_POINT: begin
        if (pt_ok) begin
          cmd.kind      = KIND_DRAW;
          cmd.col_first = x_a;
          cmd.col_last  = x_a;
          cmd.row_first = y_a;
          cmd.row_last  = y_a;
        end else begin
          cmd.kind = KIND_DONE;
          cmd.oor  = 1'b1;
        end
      end
      FUNC_FILL: begin
        if (fill_ok) begin
          cmd.kind      = KIND_DRAW;
          cmd.col_first = col_lo;
          cmd.col_last  = 8'(col_end - 9'd1);
          cmd.row_first = row_lo;
          cmd.row_last  = 8'(row_end - 9'd1);
        end else begin
          cmd.kind = KIND_DONE;
        end
      end
      FUNC_CLEAR: begin
        cmd.kind = KIND_CLEAR;
      end
      default: begin
        if (rd_ok) begin
          cmd.kind      = KIND_READ;
          cmd.col_first = x_a;
          cmd.row_first = {y_a[4:0], 3'b000};
        end else begin
          cmd.kind = KIND_DONE;
          cmd.oor  = 1'b1;
        end
      end
    endcase
  end

endmodule

FILE: hw/rtl/pmfb_back.sv
// execution engine: owns the frame memory, walks draws and clears byte by byte
// depends on pmfb_pkg
module pmfb_back import pmfb_pkg::*; #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_empty,
  input  cmd_t cmd_head,
  output logic cmd_pop,
  input  logic res_full,
  output logic res_push,
  output res_t res_data
);

  localparam int DEPTH = COLUMNS * PAGES;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [7:0] LAST_COL  = 8'(COLUMNS - 1);
  localparam logic [4:0] LAST_PAGE = 5'(PAGES - 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_RMW_RD = 3'd1;
  localparam logic [2:0] ST_RMW_WR = 3'd2;
  localparam logic [2:0] ST_CLEAR  = 3'd3;
  localparam logic [2:0] ST_READ   = 3'd4;

  logic [7:0] mem [DEPTH];
  logic [7:0] mem_q;

  logic [2:0] state;
  logic [2:0] state_next;
  cmd_t       cur;
  cmd_t       cur_next;
  logic [4:0] page;
  logic [4:0] page_next;
  logic [7:0] col;
  logic [7:0] col_next;

  logic          rd_en;
  logic [4:0]    rd_page;
  logic [7:0]    rd_col;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [7:0]    wr_data;
  logic [AW-1:0] wr_addr;
  logic [7:0]    mask;
  logic [7:0]    row_idx;
  logic [7:0]    modified;
  logic          start;

  assign rd_addr = AW'(AW'(rd_page) * AW'(COLUMNS) + AW'(rd_col));
  assign wr_addr = AW'(AW'(page) * AW'(COLUMNS) + AW'(col));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // rows of the current page that fall inside the rectangle
  always_comb begin
    mask    = '0;
    row_idx = '0;
    for (int i = 0; i < 8; i++) begin
      row_idx = {page, 3'(i)};
      mask[i] = (row_idx >= cur.row_first) && (row_idx <= cur.row_last);
    end
    case (cur.mode)
      MODE_ON:     modified = mem_q | mask;
      MODE_INVERT: modified = mem_q ^ mask;
      default:     modified = mem_q & ~mask;
    endcase
  end

  assign start   = !cmd_empty && !res_full;
  assign cmd_pop = (state == ST_IDLE) && start;

  always_comb begin
    state_next = state;
    cur_next   = cur;
    page_next  = page;
    col_next   = col;
    rd_en      = 1'b0;
    rd_page    = page;
    rd_col     = col;
    wr_en      = 1'b0;
    wr_data    = modified;
    res_push   = 1'b0;
    res_data   = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cur_next = cmd_head;
          case (cmd_head.kind)
            KIND_DRAW: begin
              page_next  = cmd_head.row_first[7:3];
              col_next   = cmd_head.col_first;
              state_next = ST_RMW_RD;
            end
            KIND_CLEAR: begin
              page_next  = '0;
              col_next   = '0;
              state_next = ST_CLEAR;
            end
            KIND_READ: begin
              rd_en      = 1'b1;
              rd_page    = cmd_head.row_first[7:3];
              rd_col     = cmd_head.col_first;
              state_next = ST_READ;
            end
            default: begin
              res_push     = 1'b1;
              res_data.oor = cmd_head.oor;
            end
          endcase
        end
      end
      ST_RMW_RD: begin
        rd_en      = 1'b1;
        state_next = ST_RMW_WR;
      end
      ST_RMW_WR: begin
        wr_en      = 1'b1;
        state_next = ST_RMW_RD;
        if (col == cur.col_last) begin
          col_next = cur.col_first;
          if (page == cur.row_last[7:3]) begin
            res_push   = 1'b1;
            page_next  = '0;
            col_next   = '0;
            state_next = ST_IDLE;
          end else begin
            page_next = page + 1'b1;
          end
        end else begin
          col_next = col + 1'b1;
        end
      end
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = (cur.mode == MODE_ON) ? BYTE_ONES : BYTE_ZEROS;
        if (col == LAST_COL) begin
          col_next = '0;
          if (page == LAST_PAGE) begin
            res_push   = 1'b1;
            page_next  = '0;
            state_next = ST_IDLE;
          end else begin
            page_next = page + 1'b1;
          end
        end else begin
          col_next = col + 1'b1;
        end
      end
      ST_READ: begin
        res_push           = 1'b1;
        res_data.read_byte = mem_q;
        state_next         = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    if (rst) begin
      state <= ST_IDLE;
      page  <= '0;
      col   <= '0;
    end else begin
      state <= state_next;
      page  <= page_next;
      col   <= col_next;
    end
  end

endmodule

FILE: hw/rtl/paged_mono_framebuffer.sv
// top level of the paged mono framebuffer: classifier, request queue, engine
// depends on pmfb_pkg, pmfb_fifo, pmfb_front and pmfb_back
//
// Monochrome frame store of COLUMNS columns by PAGES pages; each byte is a
// vertical strip of 8 pixels, pixel (x, y) being bit y mod 8 of the byte at
// page y/8, column x. Requests enter through a queue-style port (push/full)
// and every request gives exactly one result through a second queue
// (empty/pop): the stored byte for a read, zero otherwise, plus an
// out_of_range flag for rejected points and reads. The front classifies a
// request in the cycle it is taken, clipping rectangles against the clip
// window and the store, and drops it into a two-entry request queue. The
// back pops one request at a time and works on the single-port frame memory,
// whose read data is registered, so every byte a draw touches is a
// read-modify-write. A fill touches one byte per clipped column and
// overlapped page; a clear writes all COLUMNS*PAGES bytes directly. A
// result sits in a two-entry result queue, so new requests keep coming in
// while a result waits to be taken. The memory holds no defined content
// after reset: issue a clear before reading or drawing. Clip registers are
// written through cfg_we/cfg_index/cfg_data and must only change while no
// request is outstanding.
module paged_mono_framebuffer import pmfb_pkg::*; #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  logic       clk,
  input  logic       rst,
  // request side
  input  logic       push,
  output logic       full,
  input  logic [1:0] func,
  input  logic [7:0] x_a,
  input  logic [7:0] y_a,
  input  logic [7:0] x_b,
  input  logic [7:0] y_b,
  input  logic [1:0] pixel_mode,
  // result side
  output logic       empty,
  input  logic       pop,
  output logic [7:0] read_byte,
  output logic       out_of_range,
  // clip window registers
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  cmd_t cmd_in;
  cmd_t cmd_head;
  logic cmd_push;
  logic cmd_full;
  logic cmd_empty;
  logic cmd_pop;
  res_t res_in;
  res_t res_head;
  logic res_push;
  logic res_full;

  // classify and clip each request as it arrives
  pmfb_front #(
    .COLUMNS(COLUMNS),
    .PAGES  (PAGES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .func      (func),
    .x_a       (x_a),
    .y_a       (y_a),
    .x_b       (x_b),
    .y_b       (y_b),
    .pixel_mode(pixel_mode),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_full  (cmd_full),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in)
  );

  // request queue decouples classification from the memory walk
  pmfb_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(2)
  ) u_cmd_q (
    .clk  (clk),
    .rst  (rst),
    .push (cmd_push),
    .din  (cmd_in),
    .full (cmd_full),
    .pop  (cmd_pop),
    .dout (cmd_head),
    .empty(cmd_empty)
  );

  // memory owner; only starts a request when a result slot is free
  pmfb_back #(
    .COLUMNS(COLUMNS),
    .PAGES  (PAGES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_empty(cmd_empty),
    .cmd_head (cmd_head),
    .cmd_pop  (cmd_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res_data (res_in)
  );

  // result queue, head is shown on the result ports
  pmfb_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(2)
  ) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .din  (res_in),
    .full (res_full),
    .pop  (pop),
    .dout (res_head),
    .empty(empty)
  );

  assign full         = cmd_full;
  assign read_byte    = res_head.read_byte;
  assign out_of_range = res_head.oor;

endmodule

FILE: hw/rtl/pmfb_checker.sv
// port-level checks of the paged mono framebuffer, bound to the top level
// depends on paged_mono_framebuffer_macros.svh
`include "paged_mono_framebuffer_macros.svh"

module pmfb_checker (
  input logic       clk,
  input logic       rst,
  input logic       push,
  input logic       full,
  input logic       pop,
  input logic       empty,
  input logic [7:0] read_byte,
  input logic       out_of_range
);

  // requests taken but whose results are not yet taken
  logic [2:0] outstanding;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else if ((push && !full) && !(pop && !empty)) begin
      outstanding <= outstanding + 1'b1;
    end else if (!(push && !full) && (pop && !empty)) begin
      outstanding <= outstanding - 1'b1;
    end
  end

  `PMFB_ASSERT_RESET(a_reset_queues, empty && !full, "queues not empty after reset")
  `PMFB_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(read_byte) && $stable(out_of_range), "waiting result changed")
  `PMFB_ASSERT_NOW(a_oor_zero_byte, !empty && out_of_range, read_byte == 8'h00, "rejected request carries data")
  `PMFB_ASSERT_NOW(a_no_phantom, !empty, outstanding != 3'd0, "result without a request")

endmodule

bind paged_mono_framebuffer pmfb_checker u_pmfb_checker (.*);

FILE: dv/paged_mono_framebuffer_tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the paged mono framebuffer: directed and random requests
// depends on pmfb_pkg and paged_mono_framebuffer; a shadow frame store predicts each result
module paged_mono_framebuffer_tb;
  import pmfb_pkg::*;

  localparam int COLUMNS = 128;
  localparam int PAGES = 8;
  localparam int ROWS = PAGES * 8;
  localparam int STORE_BYTES = COLUMNS * PAGES;
  // the fourth mode code has no name in the package, it draws like off
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int RANDOM_PHASES = 10;
  localparam int REQUESTS_PER_PHASE = 200;
  // no request can leave work behind once its result is out
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] x_a;
    logic [7:0] y_a;
    logic [7:0] x_b;
    logic [7:0] y_b;
    logic [1:0] mode;
  } draw_req_t;

  // every input known from time zero, reset held high from the start
  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [1:0] func = FUNC_CLEAR;
  logic [7:0] x_a = 8'd0;
  logic [7:0] y_a = 8'd0;
  logic [7:0] x_b = 8'd0;
  logic [7:0] y_b = 8'd0;
  logic [1:0] pixel_mode = MODE_OFF;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] read_byte;
  logic       out_of_range;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_CLIP_X_LO;
  logic [7:0] cfg_data = 8'd0;

  paged_mono_framebuffer u_top (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .func        (func),
    .x_a         (x_a),
    .y_a         (y_a),
    .x_b         (x_b),
    .y_b         (y_b),
    .pixel_mode  (pixel_mode),
    .empty       (empty),
    .pop         (pop),
    .read_byte   (read_byte),
    .out_of_range(out_of_range),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // shadow copy of the frame store and the clip window
  logic [7:0] shadow_frame [STORE_BYTES];
  int         win_x_lo = 0;
  int         win_x_hi = 128;
  int         win_y_lo = 0;
  int         win_y_hi = 64;

  draw_req_t  pending_requests [$];   // filled by the stimulus, drained by the driver
  res_t       expected_results [$];   // one entry per accepted request, oldest first
  bit         req_taken = 1'b0;       // request accepted at the last rising edge
  int         req_gap = 0;
  int         pop_stall = 0;
  bit         steady = 1'b0;          // phase without any idling on either side
  int         mismatches = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  // a generous bound, far beyond the slowest correct run
  initial begin
    #100_000_000;
    $display("Some tests failed");
    $finish;
  end

  // mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // one pixel through store bounds and clip window, false when skipped
  function automatic bit plot_pixel(input int x, input int y, input logic [1:0] mode);
    int         idx;
    logic [7:0] mask;
    if (x >= COLUMNS || y >= ROWS) return 1'b0;
    if (x < win_x_lo || x >= win_x_hi) return 1'b0;
    if (y < win_y_lo || y >= win_y_hi) return 1'b0;
    idx  = (y / 8) * COLUMNS + x;
    mask = 8'd1 << (y % 8);
    case (mode)
      MODE_ON:     shadow_frame[idx] = shadow_frame[idx] | mask;
      MODE_INVERT: shadow_frame[idx] = shadow_frame[idx] ^ mask;
      default:     shadow_frame[idx] = shadow_frame[idx] & ~mask;  // off and the spare code
    endcase
    return 1'b1;
  endfunction

  // apply one accepted request to the shadow store and queue its result
  task automatic render_request(input draw_req_t r);
    res_t res;
    int   x;
    int   y;
    res.read_byte = BYTE_ZEROS;
    res.oor = 1'b0;
    case (r.func)
      FUNC_POINT: begin
        if (!plot_pixel(int'(r.x_a), int'(r.y_a), r.mode)) res.oor = 1'b1;
      end
      FUNC_FILL: begin
        // start not below end gives no pixel at all; clipped pixels are silent
        for (y = int'(r.y_a); y < r.y_b; y++)
          for (x = int'(r.x_a); x < r.x_b; x++)
            void'(plot_pixel(x, y, r.mode));
      end
      FUNC_CLEAR: begin
        for (x = 0; x < STORE_BYTES; x++)
          shadow_frame[x] = (r.mode == MODE_ON) ? BYTE_ONES : BYTE_ZEROS;
      end
      default: begin
        // reads look at the store bounds only, never at the clip window
        if (r.x_a < COLUMNS && r.y_a < PAGES) res.read_byte = shadow_frame[r.y_a * COLUMNS + r.x_a];
        else res.oor = 1'b1;
      end
    endcase
    expected_results.push_back(res);
  endtask

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endtask

  // rising edge: take requests into the predictor, check popped results
  always @(posedge clk) begin : monitor
    draw_req_t taken;
    res_t      want;
    if (!rst && push && !full) begin
      taken = '{func: func, x_a: x_a, y_a: y_a, x_b: x_b, y_b: y_b, mode: pixel_mode};
      render_request(taken);
    end
    if (!rst && pop && !empty) begin
      if (expected_results.size() == 0) begin
        flag_mismatch($sformatf("result with no request waiting: read_byte %h out_of_range %b",
                                read_byte, out_of_range));
      end else begin
        want = expected_results.pop_front();
        if (read_byte !== want.read_byte)
          flag_mismatch($sformatf("read_byte expected %h got %h", want.read_byte, read_byte));
        if (out_of_range !== want.oor)
          flag_mismatch($sformatf("out_of_range expected %b got %b", want.oor, out_of_range));
      end
    end
    req_taken <= !rst && push && !full;
  end

  // falling edge: hold the request until taken, then a gap or the next one
  always @(negedge clk) begin : driver
    draw_req_t nxt;
    if (rst) begin
      push <= 1'b0;
    end else if (!push || req_taken) begin
      if (req_gap > 0) begin
        push <= 1'b0;
        req_gap <= req_gap - 1;
      end else if (pending_requests.size() != 0) begin
        nxt = pending_requests.pop_front();
        func       <= nxt.func;
        x_a        <= nxt.x_a;
        y_a        <= nxt.y_a;
        x_b        <= nxt.x_b;
        y_b        <= nxt.y_b;
        pixel_mode <= nxt.mode;
        push       <= 1'b1;
        req_gap    <= pick_gap();
      end else begin
        push <= 1'b0;
      end
    end
  end

  // falling edge: result side stalls at random
  always @(negedge clk) begin : result_sink
    if (rst) begin
      pop <= 1'b0;
    end else if (pop_stall > 0) begin
      pop <= 1'b0;
      pop_stall <= pop_stall - 1;
    end else begin
      pop <= 1'b1;
      if ($urandom_range(0, 3) == 0) pop_stall <= pick_gap();
    end
  end

  task automatic queue_request(input logic [1:0] f, input logic [7:0] xa, input logic [7:0] ya,
                               input logic [7:0] xb, input logic [7:0] yb,
                               input logic [1:0] mode);
    pending_requests.push_back('{func: f, x_a: xa, y_a: ya, x_b: xb, y_b: yb, mode: mode});
  endtask

  task automatic queue_random_request();
    int          pick;
    logic [7:0]  xa;
    logic [7:0]  ya;
    logic [7:0]  xb;
    logic [7:0]  yb;
    logic [1:0]  mode;
    pick = $urandom_range(0, 99);
    xb   = 8'($urandom_range(0, 255));
    yb   = 8'($urandom_range(0, 255));
    mode = 2'($urandom_range(0, 3));
    if (pick < 4) begin
      // whole-store clears are slow, keep them rare
      queue_request(FUNC_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    xb, yb, mode);
    end else if (pick < 42) begin
      if ($urandom_range(0, 9) < 8) begin
        xa = 8'($urandom_range(0, COLUMNS - 1));
        ya = 8'($urandom_range(0, ROWS - 1));
      end else begin
        xa = 8'($urandom_range(0, 255));
        ya = 8'($urandom_range(0, 255));
      end
      queue_request(FUNC_POINT, xa, ya, xb, yb, mode);
    end else if (pick < 62) begin
      // mostly small rectangles near the store, a few anywhere
      if ($urandom_range(0, 19) != 0) begin
        xa = 8'($urandom_range(0, COLUMNS + 2));
        ya = 8'($urandom_range(0, ROWS + 2));
        xb = xa + 8'($urandom_range(0, 12));
        yb = ya + 8'($urandom_range(0, 10));
        if ($urandom_range(0, 9) == 0) xb = 8'($urandom_range(0, xa));  // empty or reversed
      end else begin
        xa = 8'($urandom_range(0, 255));
        ya = 8'($urandom_range(0, 255));
      end
      queue_request(FUNC_FILL, xa, ya, xb, yb, mode);
    end else begin
      if ($urandom_range(0, 19) != 0) begin
        xa = 8'($urandom_range(0, COLUMNS - 1));
        ya = 8'($urandom_range(0, PAGES - 1));
      end else begin
        xa = 8'($urandom_range(0, 255));
        ya = 8'($urandom_range(0, 255));
      end
      queue_request(FUNC_READ, xa, ya, xb, yb, mode);
    end
  endtask

  // nothing queued, nothing held, nothing owed, then a short settle
  task automatic wait_until_drained();
    while (pending_requests.size() != 0 || push || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_clip(input logic [1:0] idx, input logic [7:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_CLIP_X_LO: win_x_lo = int'(value);
      CFG_CLIP_X_HI: win_x_hi = int'(value);
      CFG_CLIP_Y_LO: win_y_lo = int'(value[6:0]);
      default:       win_y_hi = int'(value[6:0]);
    endcase
  endtask

  task automatic set_window(input int xlo, input int xhi, input int ylo, input int yhi);
    write_clip(CFG_CLIP_X_LO, xlo[7:0]);
    write_clip(CFG_CLIP_X_HI, xhi[7:0]);
    write_clip(CFG_CLIP_Y_LO, ylo[7:0]);
    write_clip(CFG_CLIP_Y_HI, yhi[7:0]);
    // new requests only go in after the last write has landed
    @(posedge clk);
  endtask

  initial begin : stimulus
    int phase;
    int n;
    int xlo;
    int xhi;
    int ylo;
    int yhi;
    int swap;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part at the reset window; the store is cleared before anything else
    queue_request(FUNC_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, MODE_ON);
    queue_request(FUNC_READ, 8'd0, 8'd0, 8'd0, 8'd0, MODE_OFF);
    queue_request(FUNC_READ, 8'd127, 8'd7, 8'd0, 8'd0, MODE_OFF);
    queue_request(FUNC_POINT, 8'd0, 8'd0, 8'd255, 8'd255, MODE_OFF);
    queue_request(FUNC_POINT, 8'd127, 8'd63, 8'd0, 8'd0, MODE_INVERT);
    queue_request(FUNC_POINT, 8'd5, 8'd9, 8'd0, 8'd0, MODE_SPARE);
    // points just past the store, and at the far corner of the field range
    queue_request(FUNC_POINT, 8'd128, 8'd0, 8'd0, 8'd0, MODE_ON);
    queue_request(FUNC_POINT, 8'd0, 8'd64, 8'd0, 8'd0, MODE_ON);
    queue_request(FUNC_POINT, 8'd255, 8'd255, 8'd0, 8'd0, MODE_ON);
    // reads beyond the store, then reads back inside it
    queue_request(FUNC_READ, 8'd128, 8'd0, 8'd0, 8'd0, MODE_OFF);
    queue_request(FUNC_READ, 8'd0, 8'd8, 8'd0, 8'd0, MODE_OFF);
    queue_request(FUNC_READ, 8'd255, 8'd255, 8'd255, 8'd255, MODE_SPARE);
    queue_request(FUNC_READ, 8'd0, 8'd0, 8'd0, 8'd0, MODE_OFF);
    queue_request(FUNC_READ, 8'd127, 8'd7, 8'd0, 8'd0, MODE_OFF);
    queue_request(FUNC_READ, 8'd5, 8'd1, 8'd0, 8'd0, MODE_OFF);
    // spare mode on a clear writes zeros
    queue_request(FUNC_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, MODE_SPARE);
    // empty rectangles: equal columns, reversed rows
    queue_request(FUNC_FILL, 8'd10, 8'd10, 8'd10, 8'd20, MODE_ON);
    queue_request(FUNC_FILL, 8'd10, 8'd20, 8'd30, 8'd19, MODE_ON);
    // rectangle hanging off the store
    queue_request(FUNC_FILL, 8'd120, 8'd60, 8'd255, 8'd255, MODE_ON);
    queue_request(FUNC_READ, 8'd127, 8'd7, 8'd0, 8'd0, MODE_OFF);
    // whole store inverted
    queue_request(FUNC_FILL, 8'd0, 8'd0, 8'd128, 8'd64, MODE_INVERT);
    queue_request(FUNC_READ, 8'd120, 8'd7, 8'd0, 8'd0, MODE_OFF);
    queue_request(FUNC_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, MODE_INVERT);
    queue_request(FUNC_FILL, 8'd3, 8'd5, 8'd4, 8'd6, MODE_ON);
    queue_request(FUNC_READ, 8'd3, 8'd0, 8'd0, 8'd0, MODE_OFF);

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_until_drained();
      case (phase)
        0: set_window(128, 0, 64, 0);   // inverted at the extremes, nothing drawn
        1: set_window(0, 128, 0, 64);   // whole store
        2: set_window(0, 1, 63, 64);    // first column, last row
        3: set_window(127, 128, 0, 1);  // last column, first row
        4: set_window(40, 40, 20, 20);  // zero-width window
        RANDOM_PHASES - 1: set_window(0, 128, 0, 64);
        default: begin
          xlo = $urandom_range(0, 128);
          xhi = $urandom_range(0, 128);
          ylo = $urandom_range(0, 64);
          yhi = $urandom_range(0, 64);
          swap = $urandom_range(0, 4);
          // keep most windows upright
          if (swap != 0 && xlo > xhi) begin n = xlo; xlo = xhi; xhi = n; end
          if (swap != 0 && ylo > yhi) begin n = ylo; ylo = yhi; yhi = n; end
          set_window(xlo, xhi, ylo, yhi);
        end
      endcase
      steady = (phase % 3 == 1);
      for (n = 0; n < REQUESTS_PER_PHASE; n++) queue_random_request();
    end

    wait_until_drained();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/pmfb_pkg.sv
hw/rtl/pmfb_fifo.sv
hw/rtl/pmfb_front.sv
hw/rtl/pmfb_back.sv
hw/rtl/paged_mono_framebuffer.sv
hw/rtl/pmfb_checker.sv
dv/paged_mono_framebuffer_tb.sv
